>>> hdl/fat12_pkg.sv
// Shared types, codes and constants of the FAT12 cluster table engine.
package fat12_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int TABLE_DEPTH_DEF  = 8192;
  localparam int MAX_CLUSTERS_DEF = 4096;

  // Command queue between the front and back ends
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Field widths
  localparam int CFG_W    = 14;
  localparam int CLU_W    = 12;
  localparam int IDX_W    = 13;
  localparam int ENTRY_W  = 16;
  localparam int TOTAL_W  = 32;

  // Entry codes
  localparam logic [ENTRY_W-1:0] INVALID_ENTRY = 16'hFFFF;
  localparam logic [CLU_W-1:0]   FIRST_DATA    = 12'd2;

  // Register reset values
  localparam logic [13:0] TABLE_BYTES_RST = 14'd6144;
  localparam logic [11:0] DATA_CLU_RST    = 12'd4085;
  localparam logic [7:0]  SPC_RST         = 8'd1;
  localparam logic [12:0] BPS_RST         = 13'd512;
  localparam logic [11:0] END_MARKER_RST  = 12'd4088;

  // Input function codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_NEXT  = 2'd1;
  localparam logic [1:0] FUNC_FREE  = 2'd2;
  localparam logic [1:0] FUNC_CHAIN = 2'd3;

  // Register indexes
  typedef enum logic [2:0] {
    REG_TABLE_BYTES   = 3'd0,
    REG_DATA_CLUSTERS = 3'd1,
    REG_SPC           = 3'd2,
    REG_BPS           = 3'd3,
    REG_END_MARKER    = 3'd4
  } reg_idx_t;

  // Decoded operation
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_NEXT,
    OP_FREE,
    OP_CHAIN
  } op_t;

  // Queued command
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       byte_value;
    logic [CLU_W-1:0] cluster;
  } cmd_t;

  // Configuration register set
  typedef struct packed {
    logic [13:0] table_bytes;
    logic [11:0] data_clusters;
    logic [7:0]  sectors_per_cluster;
    logic [12:0] bytes_per_sector;
    logic [11:0] end_marker;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_READ,
    BK_EVAL,
    BK_MUL1,
    BK_MUL2,
    BK_DONE
  } bk_state_t;

endpackage

>>> hdl/fat12_in_if.sv
// Input channel: valid/ready transfer of one table command.
interface fat12_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [12:0] byte_index;
  logic [7:0]  byte_value;
  logic [11:0] cluster;

  modport source (output valid, output func, output byte_index, output byte_value,
                  output cluster, input ready);
  modport sink   (input valid, input func, input byte_index, input byte_value,
                  input cluster, output ready);
endinterface

>>> hdl/fat12_out_if.sv
// Output channel: valid/ready transfer of one result.
interface fat12_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_entry;
  logic [31:0] byte_total;
  logic        walk_cut;

  modport source (output valid, output next_entry, output byte_total, output walk_cut,
                  input ready);
  modport sink   (input valid, input next_entry, input byte_total, input walk_cut,
                  output ready);
endinterface

>>> hdl/fat12_front.sv
// Front end: accepts input transfers, decodes the function and queues commands.
module fat12_front import fat12_pkg::*; (
  input  logic clk,
  input  logic rst,
  fat12_in_if.sink in_ch,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);

  cmd_t             fifo [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   cnt;
  logic             push;
  cmd_t             cmd_in;

  // Decode the function code
  always_comb begin
    cmd_in.byte_index = in_ch.byte_index;
    cmd_in.byte_value = in_ch.byte_value;
    cmd_in.cluster    = in_ch.cluster;
    case (in_ch.func)
      FUNC_LOAD:  cmd_in.op = OP_LOAD;
      FUNC_NEXT:  cmd_in.op = OP_NEXT;
      FUNC_FREE:  cmd_in.op = OP_FREE;
      FUNC_CHAIN: cmd_in.op = OP_CHAIN;
      default:    cmd_in.op = OP_LOAD;
    endcase
  end

  assign in_ch.ready = (cnt != QCW'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt != '0);
  assign q_cmd       = fifo[rd_ptr];

  // Store the command
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cnt <= QCW'(QDEPTH)) else $error("command queue over capacity");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> cnt != '0) else $error("pop from empty command queue");
`endif

endmodule

>>> hdl/fat12_back.sv
// Back end: table store, entry unpacking, free scan, chain walk and byte products.
module fat12_back import fat12_pkg::*; #(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_valid,
  input  cmd_t         q_cmd,
  output logic         q_pop,
  output logic         res_valid,
  input  logic         res_ready,
  output logic [15:0]  res_next,
  output logic [31:0]  res_total,
  output logic         res_cut
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CW_MAX = $clog2(MAX_CLUSTERS + 1);
  localparam int CNTW   = (CW_MAX > CLU_W) ? CW_MAX : CLU_W;
  localparam int P1W    = CNTW + 8;
  localparam logic [16:0]     DEPTH17 = 17'(TABLE_DEPTH);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_CLUSTERS);

  logic [7:0]          mem [TABLE_DEPTH];
  logic [7:0]          rd_lo;
  logic [7:0]          rd_hi;
  logic                inv_q;
  logic                odd_q;

  bk_state_t           state, state_next;
  op_t                 op, op_next;
  logic [15:0]         cur, cur_next;
  logic [CNTW-1:0]     count, count_next;
  logic                cut, cut_next;
  logic [15:0]         nxt, nxt_next;
  logic [P1W-1:0]      prod1;
  logic [31:0]         total, total_next;
  logic                mem_we;
  logic                res_load;

  logic [CLU_W-1:0]    rd_clu;
  logic [12:0]         off;
  logic [13:0]         off1;
  logic                rd_bad;
  logic [15:0]         entry;
  logic                walk_on;
  logic                scan_on;

  // Byte offset of a cluster's entry and its range guard
  always_comb begin
    rd_clu = cur[CLU_W-1:0];
    off    = {1'b0, rd_clu} + {2'b00, rd_clu[CLU_W-1:1]};
    off1   = {1'b0, off} + 14'd1;
    rd_bad = (rd_clu < FIRST_DATA) || (off1 >= cfg.table_bytes) ||
             ({3'b000, off1} >= DEPTH17);
  end

  // Unpack the 12-bit entry from the two bytes read, or give INVALID_ENTRY when out of range
  always_comb begin
    if (inv_q) begin
      entry = INVALID_ENTRY;
    end else if (odd_q) begin
      entry = {4'h0, rd_hi, rd_lo[7:4]};
    end else begin
      entry = {4'h0, rd_hi[3:0], rd_lo};
    end
  end

  assign walk_on = (cur >= 16'(FIRST_DATA)) && (cur < {4'h0, cfg.end_marker});
  assign scan_on = (cur < (16'(cfg.data_clusters) + 16'd2));

  // Table store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(q_cmd.byte_index)] <= q_cmd.byte_value;
    end
    if (state == BK_READ) begin
      rd_lo <= mem[AW'(off)];
      rd_hi <= mem[AW'(off1)];
      inv_q <= rd_bad;
      odd_q <= rd_clu[0];
    end
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_next = state;
    op_next    = op;
    cur_next   = cur;
    count_next = count;
    cut_next   = cut;
    nxt_next   = nxt;
    total_next = total;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    res_load   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          op_next    = q_cmd.op;
          cur_next   = {4'h0, q_cmd.cluster};
          count_next = '0;
          cut_next   = 1'b0;
          nxt_next   = '0;
          total_next = '0;
          case (q_cmd.op)
            OP_LOAD: begin
              mem_we = ({4'h0, q_cmd.byte_index} < DEPTH17);
            end
            OP_NEXT:  state_next = BK_READ;
            OP_FREE: begin
              cur_next   = 16'(FIRST_DATA);
              state_next = BK_CHECK;
            end
            OP_CHAIN: state_next = BK_CHECK;
            default:  state_next = BK_IDLE;
          endcase
        end
      end
      BK_CHECK: begin
        if (op == OP_FREE) begin
          state_next = scan_on ? BK_READ : BK_MUL1;
        end else if (walk_on && (count >= CNT_MAX)) begin
          cut_next   = 1'b1;
          state_next = BK_MUL1;
        end else begin
          state_next = walk_on ? BK_READ : BK_MUL1;
        end
      end
      BK_READ: state_next = BK_EVAL;
      BK_EVAL: begin
        case (op)
          OP_NEXT: begin
            nxt_next   = entry;
            state_next = BK_DONE;
          end
          OP_FREE: begin
            if (entry == '0) begin
              count_next = count + 1'b1;
            end
            cur_next   = cur + 16'd1;
            state_next = BK_CHECK;
          end
          default: begin
            count_next = count + 1'b1;
            cur_next   = entry;
            state_next = BK_CHECK;
          end
        endcase
      end
      BK_MUL1: state_next = BK_MUL2;
      BK_MUL2: begin
        total_next = 32'(prod1) * 32'(cfg.bytes_per_sector);
        state_next = BK_DONE;
      end
      BK_DONE: begin
        if (!res_valid || res_ready) begin
          res_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Hold state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op    <= op_next;
    cur   <= cur_next;
    count <= count_next;
    cut   <= cut_next;
    nxt   <= nxt_next;
    total <= total_next;
    if (state == BK_MUL1) begin
      prod1 <= P1W'(count) * P1W'(cfg.sectors_per_cluster);
    end
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_next  <= nxt;
      res_total <= total;
      res_cut   <= cut;
    end
  end

`ifndef NO_ASSERTIONS
  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    state == BK_EVAL |-> $past(state) == BK_READ) else $error("entry evaluated without read");
  a_walk_capped: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE && op == OP_CHAIN) |-> count <= CNT_MAX)
    else $error("chain walk passed the step cap");
  a_cut_at_cap: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE && cut) |-> (op == OP_CHAIN && count == CNT_MAX))
    else $error("walk cut flagged below the step cap");
`endif

endmodule

>>> hdl/fat12_cluster_table_engine_unit.sv
// Top level of the FAT12 cluster table engine: registers, front and back ends.
// Commands pass through a four-entry queue to a sequencer that owns the table
// memory (one write port, two registered read ports, one packed entry per
// read). Load bytes stream in at one per cycle while the back end is not busy
// with another item and the queue has room. A next item passes through a
// memory read, an evaluate and the done state. A free item scans every data
// cluster and a chain item walks the clusters it visits: each entry costs a
// check, a memory read and an evaluate, and the byte product runs through two registered multiplies. Register
// writes are taken any cycle but belong in idle periods. The table memory is
// not cleared; reading a byte that was never loaded gives no defined value.
module fat12_cluster_table_engine_unit import fat12_pkg::*; #(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  fat12_in_if.sink          in_ch,
  fat12_out_if.source       out_ch
);

  cfg_t cfg;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_bytes         <= TABLE_BYTES_RST;
      cfg.data_clusters       <= DATA_CLU_RST;
      cfg.sectors_per_cluster <= SPC_RST;
      cfg.bytes_per_sector    <= BPS_RST;
      cfg.end_marker          <= END_MARKER_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TABLE_BYTES:   cfg.table_bytes         <= cfg_data;
        REG_DATA_CLUSTERS: cfg.data_clusters       <= cfg_data[11:0];
        REG_SPC:           cfg.sectors_per_cluster <= cfg_data[7:0];
        REG_BPS:           cfg.bytes_per_sector    <= cfg_data[12:0];
        REG_END_MARKER:    cfg.end_marker          <= cfg_data[11:0];
        default:           cfg <= cfg;
      endcase
    end
  end

  fat12_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  fat12_back #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_next  (out_ch.next_entry),
    .res_total (out_ch.byte_total),
    .res_cut   (out_ch.walk_cut)
  );

endmodule
